// ===== hw/rtl/iom_pkg.sv =====
// Shared operation codes, status codes and request/response types of the insertion-ordered map.
`default_nettype none
package iom_pkg;

   localparam logic [3:0] MODE_READ      = 4'd0;
   localparam logic [3:0] MODE_WRITE     = 4'd1;
   localparam logic [3:0] MODE_ERASE     = 4'd2;
   localparam logic [3:0] MODE_FRONT     = 4'd3;
   localparam logic [3:0] MODE_BACK      = 4'd4;
   localparam logic [3:0] MODE_POP_FRONT = 4'd5;
   localparam logic [3:0] MODE_POP_BACK  = 4'd6;
   localparam logic [3:0] MODE_MOVE_END  = 4'd7;
   localparam logic [3:0] MODE_COUNT     = 4'd8;
   localparam logic [3:0] MODE_SIZE      = 4'd9;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic        [3:0]  mode;
      logic signed [31:0] key_in;
      logic signed [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic signed [31:0] key_out;
      logic               found;
      logic        [4:0]  entry_count;
      logic        [1:0]  status;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/iom_table.sv =====
// Entry storage, key match, ordered linked list and combinational operation update.
`default_nettype none
module iom_table #(
   parameter int CAPACITY = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            op_en,
   input  wire iom_pkg::req_type req,
   output iom_pkg::rsp_type     rsp
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int IDX_W  = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

   logic [31:0]         entry_key_ff   [CAPACITY];
   logic [31:0]         entry_key_in   [CAPACITY];
   logic [31:0]         entry_value_ff [CAPACITY];
   logic [31:0]         entry_value_in [CAPACITY];
   logic [IDX_W-1:0]    next_link_ff   [CAPACITY];
   logic [IDX_W-1:0]    next_link_in   [CAPACITY];
   logic [IDX_W-1:0]    prev_link_ff   [CAPACITY];
   logic [IDX_W-1:0]    prev_link_in   [CAPACITY];
   logic [CAPACITY-1:0] entry_valid_ff;
   logic [CAPACITY-1:0] entry_valid_in;
   logic [IDX_W-1:0]    head_ff;
   logic [IDX_W-1:0]    head_in;
   logic [IDX_W-1:0]    tail_ff;
   logic [IDX_W-1:0]    tail_in;
   logic [IDX_W-1:0]    occ_ff;
   logic [IDX_W-1:0]    occ_in;
   logic [IDX_W+4:0]    occ_wide;

   logic [CAPACITY-1:0] hit;
   logic                present;
   logic [SLOT_W-1:0]   hit_slot;
   logic                free_ok;
   logic [SLOT_W-1:0]   free_slot;

   // parallel key compare; keys are unique, so an OR-encode gives the slot
   always_comb begin
      hit_slot  = '0;
      free_ok   = 1'b0;
      free_slot = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i] = entry_valid_ff[i] && (entry_key_ff[i] == req.key_in);
         if (hit[i]) begin
            hit_slot = hit_slot | SLOT_W'(i);
         end
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!entry_valid_ff[i]) begin
            free_ok   = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign present = |hit;

   always_comb begin
      logic [IDX_W-1:0]  end_idx;
      logic              end_ok;
      logic [SLOT_W-1:0] end_slot;
      logic              do_unlink;
      logic [SLOT_W-1:0] unlink_slot;
      logic              do_append;
      logic [SLOT_W-1:0] append_slot;
      logic [31:0]       append_value;
      logic              do_update;
      logic [IDX_W-1:0]  p;
      logic [IDX_W-1:0]  n;

      entry_key_in   = entry_key_ff;
      entry_value_in = entry_value_ff;
      next_link_in   = next_link_ff;
      prev_link_in   = prev_link_ff;
      entry_valid_in = entry_valid_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;

      rsp.value_out   = '0;
      rsp.key_out     = req.key_in;
      rsp.found       = 1'b0;
      rsp.status      = iom_pkg::STATUS_OK;

      do_unlink    = 1'b0;
      unlink_slot  = hit_slot;
      do_append    = 1'b0;
      append_slot  = free_slot;
      append_value = '0;
      do_update    = 1'b0;

      end_idx  = ((req.mode == iom_pkg::MODE_FRONT) || (req.mode == iom_pkg::MODE_POP_FRONT))
                 ? head_ff : tail_ff;
      end_slot = end_idx[SLOT_W-1:0];
      end_ok   = (occ_ff != '0) && (end_idx < NIL) && entry_valid_ff[end_slot];

      case (req.mode)
         iom_pkg::MODE_READ, iom_pkg::MODE_WRITE, iom_pkg::MODE_MOVE_END: begin
            rsp.found = present;
            if (present) begin
               if (req.mode == iom_pkg::MODE_READ) begin
                  rsp.value_out = entry_value_ff[hit_slot];
               end else if (req.mode == iom_pkg::MODE_WRITE) begin
                  do_update = 1'b1;
               end else begin
                  do_unlink    = 1'b1;
                  do_append    = 1'b1;
                  append_slot  = hit_slot;
                  append_value = entry_value_ff[hit_slot];
               end
            end else if (free_ok) begin
               do_append    = 1'b1;
               append_value = (req.mode == iom_pkg::MODE_WRITE) ? req.value_in : '0;
            end else begin
               rsp.status = iom_pkg::STATUS_FULL;
            end
         end
         iom_pkg::MODE_ERASE: begin
            rsp.found = present;
            if (present) begin
               do_unlink = 1'b1;
            end else begin
               rsp.status = iom_pkg::STATUS_MISSING;
            end
         end
         iom_pkg::MODE_FRONT, iom_pkg::MODE_BACK,
         iom_pkg::MODE_POP_FRONT, iom_pkg::MODE_POP_BACK: begin
            if (!end_ok) begin
               rsp.status = iom_pkg::STATUS_EMPTY;
            end else begin
               rsp.value_out = entry_value_ff[end_slot];
               if ((req.mode == iom_pkg::MODE_POP_FRONT) ||
                   (req.mode == iom_pkg::MODE_POP_BACK)) begin
                  rsp.key_out = entry_key_ff[end_slot];
                  do_unlink   = 1'b1;
                  unlink_slot = end_slot;
               end
            end
         end
         iom_pkg::MODE_COUNT: begin
            rsp.found = present;
         end
         default: begin
         end
      endcase

      if (do_update) begin
         entry_value_in[hit_slot] = req.value_in;
      end

      p = prev_link_ff[unlink_slot];
      n = next_link_ff[unlink_slot];
      if (do_unlink) begin
         if (p < NIL) begin
            next_link_in[p[SLOT_W-1:0]] = n;
         end else begin
            head_in = n;
         end
         if (n < NIL) begin
            prev_link_in[n[SLOT_W-1:0]] = p;
         end else begin
            tail_in = p;
         end
         entry_valid_in[unlink_slot] = 1'b0;
         if (occ_in != '0) begin
            occ_in = occ_in - 1'b1;
         end
      end

      if (do_append) begin
         entry_key_in[append_slot]   = req.key_in;
         entry_value_in[append_slot] = append_value;
         entry_valid_in[append_slot] = 1'b1;
         prev_link_in[append_slot]   = tail_in;
         next_link_in[append_slot]   = NIL;
         if (tail_in < NIL) begin
            next_link_in[tail_in[SLOT_W-1:0]] = IDX_W'(append_slot);
         end else begin
            head_in = IDX_W'(append_slot);
         end
         tail_in = IDX_W'(append_slot);
         occ_in  = occ_in + 1'b1;
      end

      occ_wide        = {5'b0, occ_in};
      rsp.entry_count = occ_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         head_ff        <= NIL;
         tail_ff        <= NIL;
         occ_ff         <= '0;
      end else if (op_en) begin
         entry_valid_ff <= entry_valid_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         occ_ff         <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_en) begin
         entry_key_ff   <= entry_key_in;
         entry_value_ff <= entry_value_in;
         next_link_ff   <= next_link_in;
         prev_link_ff   <= prev_link_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/insertion_ordered_map.sv =====
// Top level of the insertion-ordered map: request register, table and response register.
//
// A bounded key/value table that keeps its entries in insertion order. One request
// enters per clock cycle unless the response is stalled, and its response passes
// through the request register and then the response register: the request is
// held in an input register, the whole operation (parallel key compare over all
// slots, lowest-free-slot pick, linked-list relink) is combinational, and the
// table state and the response register load at the same edge, so a request in the
// next cycle already sees its effect. The rate is one request per cycle; throughput
// drops only while rsp_tready is low; no clearing pass runs after reset.
`default_nettype none
module insertion_ordered_map #(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // key_in[31:0], value_in[63:32]
   input  wire logic [3:0]  req_tuser,   // mode[3:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // value_out[31:0], key_out[63:32],
                                         // entry_count[68:64], zero[71:69]
   output logic [2:0]       rsp_tuser    // found[0], status[2:1]
);

   iom_pkg::req_type req_ff;
   iom_pkg::rsp_type rsp_ff;
   iom_pkg::rsp_type rsp_in;
   logic             req_valid_ff;
   logic             rsp_valid_ff;
   logic             advance;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   iom_table #(
      .CAPACITY(CAPACITY)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .op_en (advance),
      .req   (req_ff),
      .rsp   (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff.mode     <= req_tuser;
         req_ff.key_in   <= req_tdata[31:0];
         req_ff.value_in <= req_tdata[63:32];
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.entry_count, rsp_ff.key_out, rsp_ff.value_out};
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.found};

endmodule
`default_nettype wire
